@@ hdl/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
// No dependencies; every other file of the block except qrs_div imports this package.
package qrs_pkg;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_TWO   = 2'd2,
        KIND_AZERO = 2'd3
    } root_kind_t;

    // Classification and operand signs of one request
    typedef struct packed {
        root_kind_t kind;
        logic       quad_neg;
        logic       lin_neg;
        logic       const_neg;
    } qrs_ctl_t;

    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QUEUE_PTR_WIDTH = 2;
    localparam int unsigned QUEUE_CNT_WIDTH = 3;

    // Numerator scaling: x/(2a) in Q.16 is (x << 15)/a, 2c/t in Q.16 is (c << 17)/t
    localparam int unsigned HALF_SHIFT  = 15;
    localparam int unsigned CONST_SHIFT = 17;

endpackage

@@ hdl/qrs_front.sv @@
// Front part of the quadratic root solver: magnitudes, products, discriminant, case.
// Depends on qrs_pkg.
module qrs_front #(
    parameter int unsigned COEF_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [COEF_WIDTH-1:0]               coef_quad,
    input  logic [COEF_WIDTH-1:0]               coef_lin,
    input  logic [COEF_WIDTH-1:0]               coef_const,
    input  logic                                q_full,
    output logic                                push,
    output qrs_pkg::qrs_ctl_t                   push_ctl,
    output logic [5*COEF_WIDTH+1:0]             push_data
);
    import qrs_pkg::*;

    localparam int unsigned DW = 2*COEF_WIDTH + 2;

    function automatic logic [COEF_WIDTH-1:0] mag_of(input logic [COEF_WIDTH-1:0] v);
        return v[COEF_WIDTH-1] ? COEF_WIDTH'(~v + 1'b1) : v;
    endfunction

    logic                    advance;
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                    s1_an_reg, s1_bn_reg, s1_cn_reg, s1_azero_reg;
    logic                    s2_an_reg, s2_bn_reg, s2_cn_reg, s2_azero_reg;
    logic [COEF_WIDTH-1:0]   s1_am_reg, s1_bm_reg, s1_cm_reg;
    logic [COEF_WIDTH-1:0]   s2_am_reg, s2_bm_reg, s2_cm_reg;
    logic [COEF_WIDTH-1:0]   s3_am_reg, s3_bm_reg, s3_cm_reg;
    logic [2*COEF_WIDTH-1:0] s2_bb_reg, s2_ac_reg;
    qrs_ctl_t                s3_ctl_reg, s3_ctl_next;
    logic [DW-1:0]           s3_dmag_reg, s3_dmag_next;
    logic [DW-1:0]           bb_x, ac4, d_sum, d_pos, d_neg;
    logic                    mixed, lt, eq, dzero;

    assign advance  = !s3_valid_reg || !q_full;
    assign in_ready = advance;

    // Discriminant magnitude and sign
    always_comb
    begin
        bb_x  = DW'(s2_bb_reg);
        ac4   = {s2_ac_reg, 2'b00};
        d_sum = bb_x + ac4;
        d_pos = bb_x - ac4;
        d_neg = ac4 - bb_x;
        lt    = bb_x < ac4;
        eq    = bb_x == ac4;
        mixed = s2_an_reg != s2_cn_reg;
        dzero = eq && (!mixed || (ac4 == '0));
        s3_dmag_next = mixed ? d_sum : (lt ? d_neg : d_pos);
        s3_ctl_next.quad_neg  = s2_an_reg;
        s3_ctl_next.lin_neg   = s2_bn_reg;
        s3_ctl_next.const_neg = s2_cn_reg;
        if (s2_azero_reg)
            s3_ctl_next.kind = KIND_AZERO;
        else if (!mixed && lt)
            s3_ctl_next.kind = KIND_NONE;
        else if (dzero)
            s3_ctl_next.kind = KIND_ONE;
        else
            s3_ctl_next.kind = KIND_TWO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_an_reg    <= coef_quad[COEF_WIDTH-1];
            s1_bn_reg    <= coef_lin[COEF_WIDTH-1];
            s1_cn_reg    <= coef_const[COEF_WIDTH-1];
            s1_azero_reg <= coef_quad == '0;
            s1_am_reg    <= mag_of(coef_quad);
            s1_bm_reg    <= mag_of(coef_lin);
            s1_cm_reg    <= mag_of(coef_const);

            s2_an_reg    <= s1_an_reg;
            s2_bn_reg    <= s1_bn_reg;
            s2_cn_reg    <= s1_cn_reg;
            s2_azero_reg <= s1_azero_reg;
            s2_am_reg    <= s1_am_reg;
            s2_bm_reg    <= s1_bm_reg;
            s2_cm_reg    <= s1_cm_reg;
            s2_bb_reg    <= s1_bm_reg * s1_bm_reg;
            s2_ac_reg    <= s1_am_reg * s1_cm_reg;

            s3_ctl_reg   <= s3_ctl_next;
            s3_dmag_reg  <= s3_dmag_next;
            s3_am_reg    <= s2_am_reg;
            s3_bm_reg    <= s2_bm_reg;
            s3_cm_reg    <= s2_cm_reg;
        end
    end

    assign push      = s3_valid_reg && !q_full;
    assign push_ctl  = s3_ctl_reg;
    assign push_data = {s3_dmag_reg, s3_cm_reg, s3_bm_reg, s3_am_reg};

endmodule

@@ hdl/qrs_queue.sv @@
// Short queue between the front and back parts of the quadratic root solver.
// Depends on qrs_pkg.
module qrs_queue #(
    parameter int unsigned DATA_WIDTH = 162
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  qrs_pkg::qrs_ctl_t     push_ctl,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  nonempty,
    output qrs_pkg::qrs_ctl_t     pop_ctl,
    output logic [DATA_WIDTH-1:0] pop_data
);
    import qrs_pkg::*;

    qrs_ctl_t                   ctl_mem [0:QUEUE_DEPTH-1];
    logic [DATA_WIDTH-1:0]      data_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_WIDTH-1:0] count_reg, count_next;

    assign full     = count_reg == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_ctl  = ctl_mem[rd_ptr_reg];
    assign pop_data = data_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/qrs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the root solver.
// No package dependency.
module qrs_div #(
    parameter int unsigned NUM_WIDTH = 49,
    parameter int unsigned DEN_WIDTH = 34
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    output logic [NUM_WIDTH-1:0] quot
);
    logic [DEN_WIDTH-1:0] rem_reg [0:NUM_WIDTH-1];
    logic [NUM_WIDTH-1:0] num_reg [0:NUM_WIDTH-1];
    logic [DEN_WIDTH-1:0] den_reg [0:NUM_WIDTH-1];
    logic [NUM_WIDTH-1:0] q_reg   [0:NUM_WIDTH-1];
    logic [DEN_WIDTH-1:0] src_rem [0:NUM_WIDTH-1];
    logic [NUM_WIDTH-1:0] src_num [0:NUM_WIDTH-1];
    logic [DEN_WIDTH-1:0] src_den [0:NUM_WIDTH-1];
    logic [NUM_WIDTH-1:0] src_q   [0:NUM_WIDTH-1];
    logic [DEN_WIDTH:0]   rx      [0:NUM_WIDTH-1];
    logic                 ge      [0:NUM_WIDTH-1];

    always_comb
    begin
        src_rem[0] = '0;
        src_num[0] = num;
        src_den[0] = den;
        src_q[0]   = '0;
        for (int j = 1; j < NUM_WIDTH; j++)
        begin
            src_rem[j] = rem_reg[j-1];
            src_num[j] = num_reg[j-1];
            src_den[j] = den_reg[j-1];
            src_q[j]   = q_reg[j-1];
        end
        for (int j = 0; j < NUM_WIDTH; j++)
        begin
            rx[j] = {src_rem[j], src_num[j][NUM_WIDTH-1]};
            ge[j] = rx[j] >= {1'b0, src_den[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NUM_WIDTH; j++)
            begin
                rem_reg[j] <= ge[j] ? DEN_WIDTH'(rx[j] - {1'b0, src_den[j]})
                                    : DEN_WIDTH'(rx[j]);
                num_reg[j] <= src_num[j] << 1;
                den_reg[j] <= src_den[j];
                q_reg[j]   <= {src_q[j][NUM_WIDTH-2:0], ge[j]};
            end
        end
    end

    assign quot = q_reg[NUM_WIDTH-1];

endmodule

@@ hdl/qrs_back.sv @@
// Back part of the quadratic root solver: square root, two dividers, clip and order.
// Depends on qrs_pkg and qrs_div.
module qrs_back #(
    parameter int unsigned COEF_WIDTH = 32,
    parameter int unsigned ROOT_WIDTH = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_pop,
    input  qrs_pkg::qrs_ctl_t           in_ctl,
    input  logic [5*COEF_WIDTH+1:0]     in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output qrs_pkg::root_kind_t         out_kind,
    output logic [ROOT_WIDTH-1:0]       out_first,
    output logic [ROOT_WIDTH-1:0]       out_second,
    output logic                        out_sat
);
    import qrs_pkg::*;

    localparam int unsigned DW  = 2*COEF_WIDTH + 2;
    localparam int unsigned NS  = COEF_WIDTH + 1;
    localparam int unsigned SRW = COEF_WIDTH + 3;
    localparam int unsigned NW  = COEF_WIDTH + CONST_SHIFT;
    localparam int unsigned DNW = COEF_WIDTH + 2;
    localparam int unsigned CW  = ((NW > ROOT_WIDTH) ? NW : ROOT_WIDTH) + 1;

    // Clip a quotient to the signed root range; result is {sat, value}
    function automatic logic [ROOT_WIDTH:0] clip(input logic [NW-1:0] q, input logic neg);
        logic [CW-1:0] qx;
        logic [CW-1:0] lim;
        qx  = CW'(q);
        lim = CW'(1) << (ROOT_WIDTH-1);
        if (neg)
        begin
            if (qx > lim)
                return {1'b1, 1'b1, {(ROOT_WIDTH-1){1'b0}}};
            return {1'b0, ROOT_WIDTH'(~qx + 1'b1)};
        end
        if (qx > lim - 1'b1)
            return {1'b1, 1'b0, {(ROOT_WIDTH-1){1'b1}}};
        return {1'b0, ROOT_WIDTH'(qx)};
    endfunction

    logic                  en;

    logic                  sq_valid_reg [0:NS];
    qrs_ctl_t              sq_ctl_reg   [0:NS];
    logic [COEF_WIDTH-1:0] sq_am_reg    [0:NS];
    logic [COEF_WIDTH-1:0] sq_bm_reg    [0:NS];
    logic [COEF_WIDTH-1:0] sq_cm_reg    [0:NS];
    logic [SRW-1:0]        sq_rem_reg   [0:NS];
    logic [NS-1:0]         sq_root_reg  [0:NS];
    logic [DW-1:0]         sq_v_reg     [0:NS];
    logic [SRW+1:0]        sq_rx        [0:NS-1];
    logic [SRW+1:0]        sq_trial     [0:NS-1];
    logic                  sq_ge        [0:NS-1];

    logic                  p_valid_reg;
    qrs_ctl_t              p_ctl_reg;
    logic [NW-1:0]         p_num_a_reg, p_num_b_reg, p_num_a_next, p_num_b_next;
    logic [DNW-1:0]        p_den_a_reg, p_den_b_reg, p_den_b_next;
    logic                  p_neg_a_reg, p_neg_b_reg, p_neg_b_next;
    logic [NS-1:0]         root_s;
    logic [DNW-1:0]        sum_t;
    logic                  two;

    logic                  dv_valid_reg [0:NW-1];
    qrs_ctl_t              dv_ctl_reg   [0:NW-1];
    logic                  dv_neg_a_reg [0:NW-1];
    logic                  dv_neg_b_reg [0:NW-1];
    logic [NW-1:0]         quot_a, quot_b;
    logic [ROOT_WIDTH:0]   fix_a, fix_b;

    logic                  f_valid_reg, f_sat_reg, f_sat_next;
    root_kind_t            f_kind_reg;
    logic [ROOT_WIDTH-1:0] f_first_reg, f_second_reg, f_first_next, f_second_next;
    logic                  swap;

    logic                  out_valid_reg;
    root_kind_t            out_kind_reg;
    logic [ROOT_WIDTH-1:0] out_first_reg, out_second_reg;
    logic                  out_sat_reg;

    // The whole back pipeline advances together; hold it while the result waits
    assign en     = !out_valid_reg || out_ready;
    assign in_pop = en && in_valid;

    // Square root, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            sq_rx[k]    = {sq_rem_reg[k], sq_v_reg[k][DW-1 -: 2]};
            sq_trial[k] = (SRW+2)'({sq_root_reg[k], 2'b01});
            sq_ge[k]    = sq_rx[k] >= sq_trial[k];
        end
    end

    // Numerators and divisors for the case
    always_comb
    begin
        root_s = sq_root_reg[NS];
        sum_t  = DNW'(sq_bm_reg[NS]) + DNW'(root_s);
        two    = sq_ctl_reg[NS].kind == KIND_TWO;
        if (two)
        begin
            p_num_a_next = NW'(sum_t) << HALF_SHIFT;
            p_num_b_next = NW'(sq_cm_reg[NS]) << CONST_SHIFT;
            p_den_b_next = sum_t;
            p_neg_b_next = sq_ctl_reg[NS].const_neg == sq_ctl_reg[NS].lin_neg;
        end
        else
        begin
            p_num_a_next = NW'(sq_bm_reg[NS]) << HALF_SHIFT;
            p_num_b_next = NW'(root_s) << HALF_SHIFT;
            p_den_b_next = DNW'(sq_am_reg[NS]);
            p_neg_b_next = 1'b0;
        end
    end

    qrs_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DNW)) u_div_a (
        .clk  (clk),
        .en   (en),
        .num  (p_num_a_reg),
        .den  (p_den_a_reg),
        .quot (quot_a)
    );

    qrs_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DNW)) u_div_b (
        .clk  (clk),
        .en   (en),
        .num  (p_num_b_reg),
        .den  (p_den_b_reg),
        .quot (quot_b)
    );

    // Clip and pick per case
    always_comb
    begin
        fix_a = clip(quot_a, dv_neg_a_reg[NW-1]);
        fix_b = clip(quot_b, dv_neg_b_reg[NW-1]);
        case (dv_ctl_reg[NW-1].kind)
            KIND_AZERO:
            begin
                f_first_next  = '0;
                f_second_next = '0;
                f_sat_next    = 1'b0;
            end
            KIND_ONE:
            begin
                f_first_next  = fix_a[ROOT_WIDTH-1:0];
                f_second_next = fix_a[ROOT_WIDTH-1:0];
                f_sat_next    = fix_a[ROOT_WIDTH];
            end
            default:
            begin
                f_first_next  = fix_a[ROOT_WIDTH-1:0];
                f_second_next = fix_b[ROOT_WIDTH-1:0];
                f_sat_next    = fix_a[ROOT_WIDTH] || fix_b[ROOT_WIDTH];
            end
        endcase
    end

    assign swap = (f_kind_reg == KIND_TWO) && ($signed(f_first_reg) > $signed(f_second_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                sq_valid_reg[k] <= 1'b0;
            p_valid_reg <= 1'b0;
            for (int j = 0; j < NW; j++)
                dv_valid_reg[j] <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= in_valid;
            for (int k = 0; k < NS; k++)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            p_valid_reg     <= sq_valid_reg[NS];
            dv_valid_reg[0] <= p_valid_reg;
            for (int j = 1; j < NW; j++)
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            f_valid_reg   <= dv_valid_reg[NW-1];
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ctl_reg[0]  <= in_ctl;
            sq_am_reg[0]   <= in_data[COEF_WIDTH-1:0];
            sq_bm_reg[0]   <= in_data[2*COEF_WIDTH-1:COEF_WIDTH];
            sq_cm_reg[0]   <= in_data[3*COEF_WIDTH-1:2*COEF_WIDTH];
            sq_v_reg[0]    <= in_data[3*COEF_WIDTH+DW-1:3*COEF_WIDTH];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < NS; k++)
            begin
                sq_ctl_reg[k+1]  <= sq_ctl_reg[k];
                sq_am_reg[k+1]   <= sq_am_reg[k];
                sq_bm_reg[k+1]   <= sq_bm_reg[k];
                sq_cm_reg[k+1]   <= sq_cm_reg[k];
                sq_v_reg[k+1]    <= sq_v_reg[k] << 2;
                sq_rem_reg[k+1]  <= sq_ge[k] ? SRW'(sq_rx[k] - sq_trial[k]) : SRW'(sq_rx[k]);
                sq_root_reg[k+1] <= {sq_root_reg[k][NS-2:0], sq_ge[k]};
            end

            p_ctl_reg   <= sq_ctl_reg[NS];
            p_num_a_reg <= p_num_a_next;
            p_den_a_reg <= DNW'(sq_am_reg[NS]);
            p_neg_a_reg <= sq_ctl_reg[NS].lin_neg == sq_ctl_reg[NS].quad_neg;
            p_num_b_reg <= p_num_b_next;
            p_den_b_reg <= p_den_b_next;
            p_neg_b_reg <= p_neg_b_next;

            dv_ctl_reg[0]   <= p_ctl_reg;
            dv_neg_a_reg[0] <= p_neg_a_reg;
            dv_neg_b_reg[0] <= p_neg_b_reg;
            for (int j = 1; j < NW; j++)
            begin
                dv_ctl_reg[j]   <= dv_ctl_reg[j-1];
                dv_neg_a_reg[j] <= dv_neg_a_reg[j-1];
                dv_neg_b_reg[j] <= dv_neg_b_reg[j-1];
            end

            f_kind_reg   <= dv_ctl_reg[NW-1].kind;
            f_first_reg  <= f_first_next;
            f_second_reg <= f_second_next;
            f_sat_reg    <= f_sat_next;

            out_kind_reg   <= f_kind_reg;
            out_first_reg  <= swap ? f_second_reg : f_first_reg;
            out_second_reg <= swap ? f_first_reg : f_second_reg;
            out_sat_reg    <= f_sat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_sat    = out_sat_reg;

endmodule

@@ hdl/quadratic_root_solver_unit.sv @@
// Top level of the quadratic root solver: front part, queue and back part.
// Depends on qrs_pkg, qrs_front, qrs_queue, qrs_back.
//
// Usage:
//   Send one request per coefficient set a, b, c (signed Q16.16) on the s_axis
//   channel; a request is taken on a clock edge where s_axis_tvalid and
//   s_axis_tready are both high. Every request yields exactly one result on
//   m_axis, in request order: the root kind in tuser, and two signed Q32.16
//   values in tdata (ascending roots, or real and imaginary part).
//   Throughput is one request per cycle while m_axis_tready is high. Results
//   pass through the square root pipeline (one result bit per stage)
//   followed by the restoring dividers (one quotient bit per stage).
//   Reset clears all valid flags and empties the queue; no result is pending
//   afterwards. When m_axis_tready drops, the back pipeline holds; the front
//   keeps taking requests until the four-entry queue fills, then drops
//   s_axis_tready.
module quadratic_root_solver_unit #(
    parameter int unsigned COEF_WIDTH = 32,
    parameter int unsigned ROOT_WIDTH = 48
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // coef_quad, coef_lin, coef_const (lowest first), zero padded to bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // first_value, second_value (lowest first), zero padded to bytes
    output logic [((2*ROOT_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // root_kind[1:0], saturated[2]
    output logic [2:0]                                m_axis_tuser
);
    import qrs_pkg::*;

    localparam int unsigned OUT_DATA_WIDTH = ((2*ROOT_WIDTH+7)/8)*8;
    localparam int unsigned QDW            = 5*COEF_WIDTH + 2;

    logic                  push, q_full, q_nonempty, q_pop;
    qrs_ctl_t              push_ctl, pop_ctl;
    logic [QDW-1:0]        push_data, pop_data;
    root_kind_t            out_kind;
    logic [ROOT_WIDTH-1:0] out_first, out_second;
    logic                  out_sat;

    // Classify and form the discriminant
    qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .coef_quad  (s_axis_tdata[COEF_WIDTH-1:0]),
        .coef_lin   (s_axis_tdata[2*COEF_WIDTH-1:COEF_WIDTH]),
        .coef_const (s_axis_tdata[3*COEF_WIDTH-1:2*COEF_WIDTH]),
        .q_full     (q_full),
        .push       (push),
        .push_ctl   (push_ctl),
        .push_data  (push_data)
    );

    // Decouple the front from back-pressure on the result side
    qrs_queue #(.DATA_WIDTH(QDW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_ctl   (pop_ctl),
        .pop_data  (pop_data)
    );

    // Square root, divide, clip and order
    qrs_back #(.COEF_WIDTH(COEF_WIDTH), .ROOT_WIDTH(ROOT_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_nonempty),
        .in_pop     (q_pop),
        .in_ctl     (pop_ctl),
        .in_data    (pop_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_first  (out_first),
        .out_second (out_second),
        .out_sat    (out_sat)
    );

    assign m_axis_tdata = OUT_DATA_WIDTH'({out_second, out_first});
    assign m_axis_tuser = {out_sat, out_kind};

endmodule
